@@ sv/bfmi_pkg.sv @@
package bfmi_pkg;

  localparam int FIELD_W     = 64;
  localparam int REQ_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int DEG_CFG_W   = 7;
  localparam int MIN_DEGREE  = 8;

  localparam logic [DEG_CFG_W-1:0] DEGREE_RESET = 7'd64;
  localparam logic [FIELD_W-1:0]   POLY_RESET   = 64'd27;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD = 2'd0,
    REQ_MUL = 2'd1,
    REQ_INV = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_DEGREE   = 1'd0,
    REG_REDUCTION_POLY = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic done;
    logic zero_inv;
  } core_sts_t;

endpackage

@@ sv/bfmi_core.sv @@
module bfmi_core #(
  parameter int MAX_DEGREE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  bfmi_pkg::req_t                     req_i,
  input  logic [MAX_DEGREE-1:0]              op_a_i,
  input  logic [MAX_DEGREE-1:0]              op_b_i,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]    m_i,
  input  logic [MAX_DEGREE-1:0]              mask_i,
  input  logic [MAX_DEGREE-1:0]              low_i,
  input  logic                               res_free_i,
  output logic                               busy_o,
  output bfmi_pkg::core_sts_t                sts_o,
  output logic [MAX_DEGREE-1:0]              result_o
);
  import bfmi_pkg::*;

  localparam int W  = MAX_DEGREE;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = $clog2(MAX_DEGREE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_INV_LEN,
    S_INV_SETU,
    S_INV_SETZ,
    S_INV_SCAN,
    S_INV_TEST,
    S_INV_XU,
    S_INV_XZ,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [W-1:0]    u_r, u_nxt;
  logic [W-1:0]    v_r, v_nxt;
  logic [W-1:0]    z_r, z_nxt;
  logic [W-1:0]    g_r, g_nxt;
  logic [W-1:0]    res_r, res_nxt;
  logic            err_r, err_nxt;
  logic [DW-1:0]   lu_r, lu_nxt;
  logic [DW-1:0]   lv_r, lv_nxt;
  logic [DW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   sh_r, sh_nxt;

  logic [W-1:0]    a_m;
  logic [W-1:0]    b_m;
  logic [W-1:0]    shf_in;
  logic [IW-1:0]   shf_amt;
  logic [W-1:0]    shf_out;
  logic [W-1:0]    mul_a;
  logic [IW-1:0]   m_top;
  logic [IW-1:0]   lu_top;
  logic [IW-1:0]   lv_top;

  assign a_m    = op_a_i & mask_i;
  assign b_m    = op_b_i & mask_i;
  assign m_top  = IW'(m_i - 1'b1);
  assign lu_top = IW'(lu_r - 1'b1);
  assign lv_top = IW'(lv_r - 1'b1);

  // The one shifter serves the multiply steps and every aligned xor of the inversion.
  always_comb begin
    case (state_r)
      S_MUL: begin
        shf_in  = u_r;
        shf_amt = IW'(1);
      end
      S_INV_SETZ: begin
        shf_in  = W'(1);
        shf_amt = sh_r;
      end
      S_INV_XZ: begin
        shf_in  = g_r;
        shf_amt = sh_r;
      end
      default: begin
        shf_in  = v_r;
        shf_amt = sh_r;
      end
    endcase
  end

  assign shf_out = shf_in << shf_amt;
  assign mul_a   = (shf_out & mask_i) ^ (u_r[m_top] ? low_i : '0);

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    z_nxt     = z_r;
    g_nxt     = g_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    lu_nxt    = lu_r;
    lv_nxt    = lv_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          err_nxt = 1'b0;
          res_nxt = '0;
          case (req_i)
            REQ_ADD: begin
              res_nxt   = a_m ^ b_m;
              state_nxt = S_DONE;
            end
            REQ_MUL: begin
              u_nxt     = a_m;
              v_nxt     = b_m >> 1;
              z_nxt     = b_m[0] ? a_m : '0;
              cnt_nxt   = m_i - 1'b1;
              state_nxt = S_MUL;
            end
            REQ_INV: begin
              if (a_m == '0) begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else if (a_m == W'(1)) begin
                res_nxt   = W'(1);
                state_nxt = S_DONE;
              end else begin
                v_nxt     = a_m;
                lv_nxt    = m_i;
                state_nxt = S_INV_LEN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_MUL: begin
        if (cnt_r == '0) begin
          res_nxt   = z_r;
          state_nxt = S_DONE;
        end else begin
          u_nxt   = mul_a;
          z_nxt   = v_r[0] ? (z_r ^ mul_a) : z_r;
          v_nxt   = v_r >> 1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_INV_LEN: begin
        if (lv_r != '0 && !v_r[lv_top]) begin
          lv_nxt = lv_r - 1'b1;
        end else begin
          sh_nxt    = IW'(m_i - lv_r + 1'b1);
          state_nxt = S_INV_SETU;
        end
      end
      S_INV_SETU: begin
        u_nxt     = low_i ^ (shf_out & mask_i);
        lu_nxt    = m_i;
        state_nxt = S_INV_SETZ;
      end
      S_INV_SETZ: begin
        z_nxt     = shf_out;
        g_nxt     = W'(1);
        state_nxt = S_INV_SCAN;
      end
      S_INV_SCAN: begin
        if (lu_r != '0 && !u_r[lu_top]) begin
          lu_nxt = lu_r - 1'b1;
        end else begin
          state_nxt = S_INV_TEST;
        end
      end
      S_INV_TEST: begin
        if (u_r == W'(1)) begin
          res_nxt   = z_r & mask_i;
          state_nxt = S_DONE;
        end else if (u_r == '0) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else if (lu_r < lv_r) begin
          u_nxt     = v_r;
          v_nxt     = u_r;
          z_nxt     = g_r;
          g_nxt     = z_r;
          lu_nxt    = lv_r;
          lv_nxt    = lu_r;
          sh_nxt    = IW'(lv_r - lu_r);
          state_nxt = S_INV_XU;
        end else begin
          sh_nxt    = IW'(lu_r - lv_r);
          state_nxt = S_INV_XU;
        end
      end
      S_INV_XU: begin
        u_nxt     = u_r ^ shf_out;
        state_nxt = S_INV_XZ;
      end
      S_INV_XZ: begin
        z_nxt     = z_r ^ shf_out;
        state_nxt = S_INV_SCAN;
      end
      S_DONE: begin
        if (res_free_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    z_r   <= z_nxt;
    g_r   <= g_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
    lu_r  <= lu_nxt;
    lv_r  <= lv_nxt;
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy_o         = (state_r != S_IDLE);
  assign sts_o.done     = (state_r == S_DONE) && res_free_i;
  assign sts_o.zero_inv = err_r;
  assign result_o       = res_r;

  a_idle_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy_o) |-> $past(sts_o.done))
    else $error("sequencer returned to idle without delivering a result");

  a_align_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INV_XU |-> (lu_r >= lv_r) && (lv_r != '0))
    else $error("inversion step aligned against the wrong operand");

  a_scan_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INV_TEST |-> (u_r >> lu_r) == '0)
    else $error("degree scan left set bits above the tracked degree");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    sts_o.done && sts_o.zero_inv |-> result_o == '0)
    else $error("zero inverse flagged with a nonzero result");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> cnt_r < m_i)
    else $error("multiply step count beyond the field degree");

endmodule

@@ sv/binary_field_mult_invert.sv @@
// Arithmetic unit for GF(2^m) in polynomial basis. Each request on the in_ channel carries
// a request type (add, multiply, invert) and two operands; it yields exactly one result on
// the out_ channel. A request is taken when in_valid is high and in_stall is low.
// The field degree and the low terms of the field polynomial are written through the cfg_
// port; register 0 is the degree, register 1 the polynomial terms. The user must write
// them only while the unit is idle; the unit itself does not enforce this. The iterative
// sequencer and its single shifter handle an add or an unknown request type directly and
// a multiply one polynomial step per cycle. An invert needs a bit scan of the operand, two
// set-up steps and, per Euclid reduction step, a degree scan, a test and two aligned xors;
// inverting zero or one is done directly.
// The unit holds in_stall high while it works on a request and through the cycle in which
// the result moves to the output register, so one request is in flight at a time; in_stall
// falls in the same cycle as out_valid rises, and the next request can be taken then.
// A finished result sits in the output register until the receiver lowers out_stall; the
// unit can accept the next request meanwhile, and that request waits in its final state if
// the output register is still occupied. Reset sets the degree to 64, the polynomial terms
// to 27, and clears the sequencer and the output valid flag.
module binary_field_mult_invert #(
  parameter int MAX_DEGREE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bfmi_pkg::REQ_W-1:0]         in_req_type,
  input  logic [bfmi_pkg::FIELD_W-1:0]       in_operand_a,
  input  logic [bfmi_pkg::FIELD_W-1:0]       in_operand_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bfmi_pkg::FIELD_W-1:0]       out_result_value,
  output logic                               out_zero_inverse_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfmi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfmi_pkg::FIELD_W-1:0]       cfg_data
);
  import bfmi_pkg::*;

  localparam int W  = MAX_DEGREE;
  localparam int DW = $clog2(MAX_DEGREE + 1);

  logic [DEG_CFG_W-1:0] degree_r;
  logic [W-1:0]         poly_r;
  logic                 out_valid_r;
  logic [W-1:0]         out_result_r;
  logic                 out_err_r;

  logic [DW-1:0]        m_eff;
  logic [W-1:0]         mask;
  logic [W-1:0]         low;
  logic                 core_busy;
  core_sts_t            core_sts;
  logic [W-1:0]         core_result;
  logic                 res_free;
  logic                 start;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RESET;
      poly_r   <= POLY_RESET[W-1:0];
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIELD_DEGREE:   degree_r <= cfg_data[DEG_CFG_W-1:0];
        REG_REDUCTION_POLY: poly_r   <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (degree_r < DEG_CFG_W'(MIN_DEGREE)) begin
      m_eff = DW'(MIN_DEGREE);
    end else if (degree_r > DEG_CFG_W'(MAX_DEGREE)) begin
      m_eff = DW'(MAX_DEGREE);
    end else begin
      m_eff = DW'(degree_r);
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i] = (DW'(i) < m_eff);
    end
  end

  assign low      = poly_r & mask;
  assign in_stall = core_busy;
  assign start    = in_valid && !in_stall;
  assign res_free = !out_valid_r || !out_stall;

  bfmi_core #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .req_i      (req_t'(in_req_type)),
    .op_a_i     (in_operand_a[W-1:0]),
    .op_b_i     (in_operand_b[W-1:0]),
    .m_i        (m_eff),
    .mask_i     (mask),
    .low_i      (low),
    .res_free_i (res_free),
    .busy_o     (core_busy),
    .sts_o      (core_sts),
    .result_o   (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_sts.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (core_sts.done) begin
      out_result_r <= core_result;
      out_err_r    <= core_sts.zero_inv;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_value       = FIELD_W'(out_result_r);
  assign out_zero_inverse_error = out_err_r;

endmodule

@@ tb/binary_field_mult_invert_test.sv @@
`timescale 1ns / 100ps

module binary_field_mult_invert_test;
  import bfmi_pkg::*;

  localparam int MAX_DEGREE = 64;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam logic [FIELD_W-1:0] ALL_ONES = '1;
  localparam logic [FIELD_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 600;
  localparam int PHASE_ITEMS = 72;
  localparam int NUM_PHASES = 11;

  typedef struct {
    logic [FIELD_W-1:0] value;
    logic               zero_inv;
  } field_result_t;

  class gf_result_tracker;
    logic [DEG_CFG_W-1:0] degree_reg;
    logic [FIELD_W-1:0]   poly_reg;
    field_result_t        pending_results[$];
    int                   failures;
    int                   checked;
    int                   zero_inv_count;

    function new();
      degree_reg = DEGREE_RESET;
      poly_reg = POLY_RESET;
      failures = 0;
      checked = 0;
      zero_inv_count = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
      if (idx == REG_FIELD_DEGREE) begin
        degree_reg = data[DEG_CFG_W-1:0];
      end else begin
        poly_reg = data;
      end
    endfunction

    function int unsigned active_degree();
      int unsigned m;
      m = degree_reg;
      if (m < MIN_DEGREE) m = MIN_DEGREE;
      if (m > MAX_DEGREE) m = MAX_DEGREE;
      return m;
    endfunction

    function int unsigned bit_count(logic [FIELD_W-1:0] x);
      int unsigned n;
      n = 0;
      for (int i = 0; i < FIELD_W; i++) begin
        if (x[i]) n = i + 1;
      end
      return n;
    endfunction

    function logic [FIELD_W-1:0] field_product(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                               int unsigned m, logic [FIELD_W-1:0] low,
                                               logic [FIELD_W-1:0] mask);
      logic [FIELD_W-1:0] acc;
      logic [FIELD_W-1:0] top;
      logic               carry;
      acc = b[0] ? a : '0;
      top = 64'd1 << (m - 1);
      for (int unsigned i = 1; i < m; i++) begin
        carry = (a & top) != 0;
        a = (a << 1) & mask;
        if (carry) a ^= low;
        if (b[i]) acc ^= a;
      end
      return acc & mask;
    endfunction

    // Binary extended Euclid; found stays low when the operand shares a factor
    // with a reducible field polynomial.
    function logic [FIELD_W-1:0] field_inverse(logic [FIELD_W-1:0] a, int unsigned m,
                                               logic [FIELD_W-1:0] low,
                                               logic [FIELD_W-1:0] mask, output bit found);
      logic [FIELD_W-1:0] u, v, z, g, t;
      int unsigned        sh, lu, lv;
      found = 1'b0;
      if (a == 1) begin
        found = 1'b1;
        return 64'd1;
      end
      sh = m - bit_count(a) + 1;
      u = low ^ ((a << sh) & mask);
      v = a;
      z = 64'd1 << sh;
      g = 64'd1;
      for (int guard = 0; guard < 4 * 64 + 4; guard++) begin
        if (u == 1) begin
          found = 1'b1;
          return z & mask;
        end
        if (u == 0) break;
        lu = bit_count(u);
        lv = bit_count(v);
        if (lu < lv) begin
          t = u; u = v; v = t;
          t = z; z = g; g = t;
          sh = lv - lu;
        end else begin
          sh = lu - lv;
        end
        if (sh > 63) break;
        u ^= v << sh;
        z ^= g << sh;
      end
      return '0;
    endfunction

    function field_result_t field_op_result(logic [REQ_W-1:0] req, logic [FIELD_W-1:0] a_in,
                                            logic [FIELD_W-1:0] b_in);
      field_result_t      res;
      int unsigned        m;
      logic [FIELD_W-1:0] mask, low, a, b;
      bit                 found;
      m = active_degree();
      mask = (m >= 64) ? ALL_ONES : ((64'd1 << m) - 1);
      low = poly_reg & mask;
      a = a_in & mask;
      b = b_in & mask;
      res.value = '0;
      res.zero_inv = 1'b0;
      case (req)
        REQ_ADD: res.value = a ^ b;
        REQ_MUL: res.value = field_product(a, b, m, low, mask);
        REQ_INV: begin
          if (a == 0) begin
            res.zero_inv = 1'b1;
          end else begin
            res.value = field_inverse(a, m, low, mask, found);
          end
        end
        default: ;
      endcase
      res.value &= mask;
      return res;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [FIELD_W-1:0] a,
                               logic [FIELD_W-1:0] b);
      field_result_t res;
      res = field_op_result(req, a, b);
      if (res.zero_inv) zero_inv_count++;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [FIELD_W-1:0] value, logic zero_inv);
      field_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: got value %h error %b", $time, value, zero_inv);
        failures++;
        return;
      end
      exp_res = pending_results.pop_front();
      checked++;
      if (value !== exp_res.value) begin
        $display("%0t: result_value mismatch: expected %h, actual %h",
                 $time, exp_res.value, value);
        failures++;
      end
      if (zero_inv !== exp_res.zero_inv) begin
        $display("%0t: zero_inverse_error mismatch: expected %b, actual %b",
                 $time, exp_res.zero_inv, zero_inv);
        failures++;
      end
    endfunction

    function void report_leftover();
      if (pending_results.size() != 0) begin
        $display("%0t: %0d results never arrived; expected value %h error %b first",
                 $time, pending_results.size(), pending_results[0].value,
                 pending_results[0].zero_inv);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type;
  logic [FIELD_W-1:0]   in_operand_a;
  logic [FIELD_W-1:0]   in_operand_b;
  logic                 out_valid;
  logic                 out_stall;
  logic [FIELD_W-1:0]   out_result_value;
  logic                 out_zero_inverse_error;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  gf_result_tracker tracker;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               stall_left;
  int               quiet_cycles;
  int               req_count[4];
  int               settings_used;

  binary_field_mult_invert #(
    .MAX_DEGREE(MAX_DEGREE)
  ) DUT (
    .*
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(16, 0);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_result_value, out_zero_inverse_error);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return 64'd1 << $urandom_range(63);
      4: return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_request();
    int r;
    r = $urandom_range(99);
    if (r < 20) return REQ_ADD;
    if (r < 55) return REQ_MUL;
    if (r < 90) return REQ_INV;
    return REQ_RESERVED;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high so back-to-back requests need no gap.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [FIELD_W-1:0] a,
                              input logic [FIELD_W-1:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(17, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = req;
    in_operand_a = a;
    in_operand_b = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req, a, b);
    req_count[req]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [FIELD_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_field(input logic [DEG_CFG_W-1:0] degree, input logic [FIELD_W-1:0] poly);
    logic [FIELD_W-1:0] data;
    wait_drained();
    data = {$urandom, $urandom};
    data[DEG_CFG_W-1:0] = degree;
    write_register(REG_FIELD_DEGREE, data);
    write_register(REG_REDUCTION_POLY, poly);
    settings_used++;
  endtask

  logic [DEG_CFG_W-1:0] phase_degree[NUM_PHASES];
  logic [FIELD_W-1:0]   phase_poly[NUM_PHASES];

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FIELD_DEGREE;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_left = 0;
    quiet_cycles = 0;
    settings_used = 1;
    foreach (req_count[i]) req_count[i] = 0;

    phase_degree = '{7'd8, 7'd0, 7'd16, 7'd32, 7'd127, 7'd13, 7'd64, 7'd63, 7'd24,
                     7'($urandom_range(127)), 7'd64};
    phase_poly = '{64'h1B, ALL_ONES, 64'h2B, 64'h8D, 64'h1B, {$urandom, $urandom} | 64'd1,
                   64'd0, {$urandom, $urandom} | 64'd1, {$urandom, $urandom},
                   {$urandom, $urandom}, POLY_RESET};

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset field: degree 64 with the default polynomial terms.
    send_request(REQ_ADD, '0, '0);
    send_request(REQ_ADD, ALL_ONES, ALL_ONES);
    send_request(REQ_ADD, ALL_ONES, '0);
    send_request(REQ_MUL, '0, ALL_ONES);
    send_request(REQ_MUL, 64'd1, ALL_ONES);
    send_request(REQ_MUL, ALL_ONES, ALL_ONES);
    send_request(REQ_MUL, TOP_BIT, 64'd2);
    send_request(REQ_INV, '0, ALL_ONES);
    send_request(REQ_INV, 64'd1, '0);
    send_request(REQ_INV, 64'd2, '0);
    send_request(REQ_INV, ALL_ONES, ALL_ONES);
    send_request(REQ_INV, TOP_BIT, '0);
    send_request(REQ_RESERVED, ALL_ONES, ALL_ONES);

    // Degree 8 with polynomial bits above the degree that must be ignored.
    set_field(7'd8, 64'hFFFF_FFFF_FFFF_FF1B);
    send_request(REQ_ADD, ALL_ONES, 64'h100);
    send_request(REQ_MUL, 64'hF00, 64'h1FF);
    send_request(REQ_INV, 64'h100, '0);
    send_request(REQ_INV, 64'h53, '0);
    send_request(REQ_INV, 64'hFF, '0);

    // A reducible polynomial leaves even elements without an inverse.
    set_field(7'd8, 64'd0);
    send_request(REQ_INV, 64'd2, '0);
    send_request(REQ_MUL, 64'h80, 64'd2);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_field(phase_degree[p], phase_poly[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == NUM_PHASES - 1) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end else if (n % 24 == 0) begin
          tx_idle_pct = pick_idle_pct();
          rx_idle_pct = pick_idle_pct();
        end
        send_request(pick_request(), pick_operand(), pick_operand());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.report_leftover();

    $display("Covered %0d add, %0d multiply, %0d invert and %0d reserved requests over %0d fields.",
             req_count[REQ_ADD], req_count[REQ_MUL], req_count[REQ_INV],
             req_count[REQ_RESERVED], settings_used);
    $display("Checked %0d results, %0d of them inversions of zero.",
             tracker.checked, tracker.zero_inv_count);
    if (tracker.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
